### rtl/core/ffpa_pkg.sv
// types and constants shared by the first-fit page allocator modules
package ffpa_pkg;

	localparam int unsigned CNT_W      = 11;
	localparam int unsigned CNT_MAX    = 2047;
	localparam int unsigned START_W    = 10;
	localparam int unsigned OFF_W      = 22;
	localparam int unsigned PAGE_SHIFT = 12;

	localparam logic [CNT_W-1:0] NUM_PAGES_RESET = 11'd1024;

	localparam logic [1:0] REQ_ALLOC = 2'd0;
	localparam logic [1:0] REQ_FREE  = 2'd1;

	localparam logic [1:0] STATUS_DONE    = 2'd0;
	localparam logic [1:0] STATUS_FAIL    = 2'd1;
	localparam logic [1:0] STATUS_IGNORED = 2'd2;

	localparam int unsigned MARK_TAKEN = 0;
	localparam int unsigned MARK_LAST  = 1;

	localparam logic [1:0] MARK_NONE     = 2'b00;
	localparam logic [1:0] MARK_RUN      = 2'b01;
	localparam logic [1:0] MARK_RUN_LAST = 2'b11;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [CNT_W-1:0] page_count;
		logic [OFF_W-1:0] free_offset;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [START_W-1:0] start_page;
		logic [CNT_W-1:0]   taken_count;
		logic [CNT_W-1:0]   free_count;
	} rsp_t;

	typedef struct packed {
		logic clear;
		logic idle;
		logic check;
		logic scan;
		logic fill;
		logic walk;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
		logic chk_alloc;
		logic chk_free;
		logic scan_hit;
		logic scan_miss;
		logic fill_last;
		logic walk_stop;
		logic out_room;
	} sts_t;

endpackage

### rtl/core/ffpa_dp.sv
// datapath: page mark memory, scan and walk pointers, counters, result register
module ffpa_dp import ffpa_pkg::*; #(
	parameter int unsigned NPAGES = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_data,
	input  logic             in_valid,
	input  req_t             in_word,
	input  logic             out_stall,
	output logic             out_valid,
	output rsp_t             out_word,
	input  cmd_t             cmd,
	output sts_t             sts
);

	localparam int unsigned AW  = (NPAGES > 1) ? $clog2(NPAGES) : 1;
	localparam int unsigned CAP = (NPAGES > CNT_MAX) ? CNT_MAX : NPAGES;

	logic [1:0]       mem [NPAGES];
	logic [1:0]       rdata_s1;
	logic             rd_vld_s1;
	logic [CNT_W-1:0] rd_pg_s1;

	req_t             req_q;
	logic [CNT_W-1:0] num_q;
	logic [CNT_W-1:0] taken_q;
	logic [CNT_W-1:0] ptr_q;
	logic [CNT_W-1:0] run_q;
	logic [CNT_W-1:0] end_q;
	logic [CNT_W-1:0] fill_q;
	logic [AW-1:0]    clr_q;
	logic [1:0]       res_status_q;
	logic [CNT_W-1:0] res_start_q;
	logic             out_valid_q;
	rsp_t             out_word_q;

	logic [CNT_W-1:0] pool;
	logic [CNT_W-1:0] free_cnt;
	logic [CNT_W-1:0] page_idx;
	logic [CNT_W-1:0] run_next;
	logic [CNT_W-1:0] first_pg;
	logic             accept;
	logic             is_alloc;
	logic             is_free;
	logic             alloc_bad;
	logic             free_bad;
	logic             taken;
	logic             last;
	logic             issue;
	logic             walk_clr;
	logic             load;
	logic             we;
	logic [AW-1:0]    waddr;
	logic [1:0]       wdata;

	assign pool     = (num_q > CNT_W'(CAP)) ? CNT_W'(CAP) : num_q;
	assign free_cnt = (pool > taken_q) ? (pool - taken_q) : '0;
	assign page_idx = CNT_W'(req_q.free_offset >> PAGE_SHIFT);
	assign run_next = run_q + 1'b1;
	assign first_pg = rd_pg_s1 + 1'b1 - req_q.page_count;
	assign accept   = cmd.idle & in_valid;
	assign is_alloc = (req_q.req_type == REQ_ALLOC);
	assign is_free  = (req_q.req_type == REQ_FREE);
	assign taken    = rdata_s1[MARK_TAKEN];
	assign last     = rdata_s1[MARK_LAST];

	assign alloc_bad = (req_q.page_count == '0) || (req_q.page_count > pool);
	assign free_bad  = (req_q.free_offset[PAGE_SHIFT-1:0] != '0) || (page_idx >= pool);

	assign sts.clear_done = (clr_q == AW'(NPAGES - 1));
	assign sts.chk_alloc  = is_alloc & ~alloc_bad;
	assign sts.chk_free   = is_free & ~free_bad;
	assign sts.scan_hit   = rd_vld_s1 & ~taken & (run_next == req_q.page_count);
	assign sts.scan_miss  = ~rd_vld_s1 & (ptr_q >= pool);
	assign sts.fill_last  = (fill_q == end_q);
	assign sts.walk_stop  = (rd_vld_s1 & (~taken | last)) | (~rd_vld_s1 & (ptr_q >= pool));
	assign sts.out_room   = ~out_valid_q | ~out_stall;

	assign issue    = ((cmd.scan & ~sts.scan_hit) | (cmd.walk & ~sts.walk_stop)) & (ptr_q < pool);
	assign walk_clr = cmd.walk & rd_vld_s1 & taken;
	assign load     = cmd.finish & sts.out_room;

	always_comb begin
		we    = 1'b0;
		waddr = clr_q;
		wdata = MARK_NONE;
		if (cmd.clear) begin
			we = 1'b1;
		end else if (cmd.fill) begin
			we    = 1'b1;
			waddr = AW'(fill_q);
			wdata = sts.fill_last ? MARK_RUN_LAST : MARK_RUN;
		end else if (walk_clr) begin
			we    = 1'b1;
			waddr = AW'(rd_pg_s1);
		end
	end

	// mark memory, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_s1 <= mem[AW'(ptr_q)];
	end

	always_ff @(posedge clk) begin
		rd_pg_s1 <= ptr_q;
		if (accept) begin
			req_q <= in_word;
		end
		if (cmd.scan & sts.scan_hit) begin
			end_q <= rd_pg_s1;
		end
		if (load) begin
			out_word_q.status      <= res_status_q;
			out_word_q.start_page  <= res_start_q[START_W-1:0];
			out_word_q.taken_count <= taken_q;
			out_word_q.free_count  <= free_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1    <= 1'b0;
			num_q        <= NUM_PAGES_RESET;
			taken_q      <= '0;
			ptr_q        <= '0;
			run_q        <= '0;
			fill_q       <= '0;
			clr_q        <= '0;
			res_status_q <= STATUS_DONE;
			res_start_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;

			if (cfg_we) begin
				num_q <= cfg_data;
				clr_q <= '0;
			end else if (cmd.clear && !sts.clear_done) begin
				clr_q <= clr_q + 1'b1;
			end

			if (cfg_we) begin
				taken_q <= '0;
			end else if (cmd.fill && sts.fill_last) begin
				taken_q <= taken_q + req_q.page_count;
			end else if (walk_clr && taken_q != '0) begin
				taken_q <= taken_q - 1'b1;
			end

			if (cmd.check) begin
				ptr_q <= is_alloc ? '0 : page_idx;
			end else if (issue) begin
				ptr_q <= ptr_q + 1'b1;
			end

			if (cmd.check) begin
				run_q <= '0;
			end else if (cmd.scan && rd_vld_s1) begin
				run_q <= taken ? '0 : run_next;
			end

			if (accept) begin
				res_status_q <= STATUS_DONE;
				res_start_q  <= '0;
			end else if (cmd.check && is_alloc && alloc_bad) begin
				res_status_q <= STATUS_FAIL;
			end else if (cmd.check && is_free && free_bad) begin
				res_status_q <= STATUS_IGNORED;
			end else if (cmd.scan && sts.scan_miss) begin
				res_status_q <= STATUS_FAIL;
			end else if (cmd.scan && sts.scan_hit) begin
				res_start_q <= first_pg;
			end

			if (cmd.scan && sts.scan_hit) begin
				fill_q <= first_pg;
			end else if (cmd.fill) begin
				fill_q <= fill_q + 1'b1;
			end

			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

### rtl/core/ffpa_ctrl.sv
// controller: request sequencing state machine
module ffpa_ctrl import ffpa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_FILL,
		S_WALK,
		S_FINISH
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (sts.clear_done) state_nxt = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) state_nxt = S_CHECK;
			end
			S_CHECK: begin
				if (sts.chk_alloc) state_nxt = S_SCAN;
				else if (sts.chk_free) state_nxt = S_WALK;
				else state_nxt = S_FINISH;
			end
			S_SCAN: begin
				if (sts.scan_hit) state_nxt = S_FILL;
				else if (sts.scan_miss) state_nxt = S_FINISH;
			end
			S_FILL: begin
				if (sts.fill_last) state_nxt = S_FINISH;
			end
			S_WALK: begin
				if (sts.walk_stop) state_nxt = S_FINISH;
			end
			S_FINISH: begin
				if (sts.out_room) state_nxt = S_IDLE;
			end
			default: state_nxt = S_CLEAR;
		endcase
		// pool write restarts the clearing pass
		if (cfg_we) state_nxt = S_CLEAR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd        = '0;
		cmd.clear  = (state_q == S_CLEAR);
		cmd.idle   = (state_q == S_IDLE);
		cmd.check  = (state_q == S_CHECK);
		cmd.scan   = (state_q == S_SCAN);
		cmd.fill   = (state_q == S_FILL);
		cmd.walk   = (state_q == S_WALK);
		cmd.finish = (state_q == S_FINISH);
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

### rtl/core/first_fit_page_allocator.sv
// top level: first-fit page allocator, controller plus datapath
// one request at a time; a count query goes through the check and finish states
// an allocation scans the pages for a free run of the asked size, then marks that run
// a free walks the pages of its run, one mark per cycle through the mark memory
// after reset and after every pool register write a clearing pass over all NPAGES pages
// zeroes the mark memory; no request word is taken during that pass
module first_fit_page_allocator import ffpa_pkg::*; #(
	parameter int unsigned NPAGES = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  req_t             in_word,
	output logic             out_valid,
	input  logic             out_stall,
	output rsp_t             out_word
);

	cmd_t cmd;
	sts_t sts;

	ffpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	ffpa_dp #(
		.NPAGES (NPAGES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_word   (in_word),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_word  (out_word),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

### test/tb.sv
// testbench for the first-fit page allocator: random and directed requests checked against a page-mark model
module tb import ffpa_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned NPAGES = 1024;
	localparam logic [1:0] REQ_COUNT = 2'd2;
	localparam logic [1:0] REQ_SPARE = 2'd3;
	localparam int unsigned GAP_MAX = 14;
	localparam int unsigned WATCHDOG_LIMIT = 20000;
	localparam int unsigned PHASES = 10;
	localparam int unsigned PHASE_POOL [PHASES] = '{2, 0, 1, 2047, 16, 64, 5, 300, 1024, 40};
	localparam int unsigned PHASE_ITEMS [PHASES] = '{40, 10, 12, 40, 100, 120, 60, 80, 40, 70};

	class page_pool_scoreboard;
		bit [1:0] marks [NPAGES];
		int unsigned taken_total;
		int unsigned pool_reg;
		rsp_t expected_q[$];
		int unsigned live_starts[$];
		int errors;

		function new();
			errors = 0;
			set_pool(NUM_PAGES_RESET);
		endfunction

		function void set_pool(int unsigned value);
			pool_reg = value;
			foreach (marks[i]) marks[i] = MARK_NONE;
			taken_total = 0;
			live_starts.delete();
		endfunction

		function int unsigned pool_pages();
			return (pool_reg > NPAGES) ? NPAGES : pool_reg;
		endfunction

		function bit alloc_run(int unsigned n, output int unsigned first);
			int unsigned pool;
			int unsigned run;
			int unsigned p;
			int unsigned k;
			pool = pool_pages();
			run = 0;
			first = 0;
			if (n == 0 || n > pool) return 1'b0;
			for (p = 0; p < pool; p++) begin
				if (marks[p][MARK_TAKEN]) begin
					run = 0;
				end else begin
					run++;
					if (run == n) begin
						first = p + 1 - n;
						for (k = first; k < p; k++) marks[k] = MARK_RUN;
						marks[p] = MARK_RUN_LAST;
						taken_total += n;
						return 1'b1;
					end
				end
			end
			return 1'b0;
		endfunction

		function bit free_run(logic [OFF_W-1:0] offset);
			int unsigned pool;
			int unsigned page;
			int unsigned i;
			pool = pool_pages();
			if (offset[PAGE_SHIFT-1:0] != '0) return 1'b0;
			page = offset >> PAGE_SHIFT;
			if (page >= pool) return 1'b0;
			for (i = page; i < pool; i++) begin
				if (!marks[i][MARK_TAKEN]) break;
				marks[i][MARK_TAKEN] = 1'b0;
				if (taken_total > 0) taken_total--;
				if (marks[i][MARK_LAST]) begin
					marks[i][MARK_LAST] = 1'b0;
					break;
				end
			end
			return 1'b1;
		endfunction

		function void note_request(req_t w);
			rsp_t r;
			int unsigned first;
			int unsigned pool;
			int unsigned page;
			int unsigned spare;
			int k;
			r.status = STATUS_DONE;
			r.start_page = '0;
			if (w.req_type == REQ_ALLOC) begin
				if (alloc_run(w.page_count, first)) begin
					r.start_page = first[START_W-1:0];
					live_starts.push_back(first);
				end else begin
					r.status = STATUS_FAIL;
				end
			end else if (w.req_type == REQ_FREE) begin
				if (!free_run(w.free_offset)) begin
					r.status = STATUS_IGNORED;
				end else begin
					page = w.free_offset >> PAGE_SHIFT;
					for (k = 0; k < live_starts.size(); k++) begin
						if (live_starts[k] == page) begin
							live_starts.delete(k);
							break;
						end
					end
				end
			end
			pool = pool_pages();
			spare = (pool > taken_total) ? pool - taken_total : 0;
			r.taken_count = taken_total[CNT_W-1:0];
			r.free_count = spare[CNT_W-1:0];
			expected_q.push_back(r);
		endfunction

		task report(string msg);
			$display("%0t mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_response(rsp_t got);
			rsp_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("result word %h with no request waiting", got));
				return;
			end
			want = expected_q.pop_front();
			if (got.status !== want.status)
				report($sformatf("status %0d, want %0d", got.status, want.status));
			if (got.start_page !== want.start_page)
				report($sformatf("start_page %0d, want %0d", got.start_page, want.start_page));
			if (got.taken_count !== want.taken_count)
				report($sformatf("taken_count %0d, want %0d", got.taken_count, want.taken_count));
			if (got.free_count !== want.free_count)
				report($sformatf("free_count %0d, want %0d", got.free_count, want.free_count));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CNT_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	req_t in_word = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	rsp_t out_word;

	page_pool_scoreboard sb = new();
	int unsigned quiet_cycles = 0;
	int unsigned stall_left = 0;
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;

	first_fit_page_allocator #(.NPAGES(NPAGES)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word(out_word)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) sb.note_request(in_word);
			if (out_valid && !out_stall) sb.check_response(out_word);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall)
				stall_left = rx_calm ? 0 : $urandom_range(0, GAP_MAX);
			else if (stall_left > 0)
				stall_left--;
			out_stall <= (stall_left > 0);
		end
	end

	initial begin
		do @(posedge clk); while (quiet_cycles < WATCHDOG_LIMIT);
		$display("FAIL first_fit_page_allocator");
		$finish;
	end

	function automatic req_t mk_word(logic [1:0] kind, int unsigned pages, int unsigned offset);
		req_t w;
		w.req_type = kind;
		w.page_count = pages[CNT_W-1:0];
		w.free_offset = offset[OFF_W-1:0];
		return w;
	endfunction

	function automatic req_t random_word(int unsigned pool);
		req_t w;
		int unsigned pick;
		int unsigned top;
		int unsigned page_hi;
		w.req_type = REQ_ALLOC;
		w.page_count = CNT_W'($urandom_range(0, CNT_MAX));
		w.free_offset = OFF_W'($urandom_range(0, (1 << OFF_W) - 1));
		pick = $urandom_range(0, 99);
		top = (pool / 3 < 2) ? 2 : pool / 3;
		page_hi = (pool + 3 > NPAGES - 1) ? NPAGES - 1 : pool + 3;
		if (pick < 42) begin
			w.page_count = CNT_W'($urandom_range(1, top));
		end else if (pick < 72) begin
			w.req_type = REQ_FREE;
			if (sb.live_starts.size() > 0)
				w.free_offset = OFF_W'(sb.live_starts[$urandom_range(0, sb.live_starts.size() - 1)]
					<< PAGE_SHIFT);
			else
				w.free_offset = OFF_W'($urandom_range(0, page_hi) << PAGE_SHIFT);
		end else if (pick < 80) begin
			w.req_type = 2'($urandom_range(REQ_COUNT, REQ_SPARE));
		end else if (pick < 85) begin
			w.page_count = CNT_W'($urandom_range(0, 1) ? 0 : $urandom_range(pool + 1, CNT_MAX));
		end else if (pick < 90) begin
			w.req_type = REQ_FREE;
			if (w.free_offset[PAGE_SHIFT-1:0] == '0) w.free_offset[$urandom_range(0, 11)] = 1'b1;
		end else if (pick < 96) begin
			w.req_type = REQ_FREE;
			w.free_offset = OFF_W'($urandom_range(0, page_hi) << PAGE_SHIFT);
		end else begin
			w.req_type = 2'($urandom_range(0, 3));
		end
		return w;
	endfunction

	task automatic send_word(input req_t w);
		int unsigned gap;
		gap = tx_calm ? 0 : $urandom_range(0, GAP_MAX);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (in_stall !== 1'b0);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_pool(input int unsigned value);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= value[CNT_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_pool(value);
	endtask

	task automatic run_directed();
		req_t seq[$];
		seq.push_back(mk_word(REQ_COUNT, 0, 0));
		seq.push_back(mk_word(REQ_SPARE, CNT_MAX, (1 << OFF_W) - 1));
		seq.push_back(mk_word(REQ_ALLOC, 0, 0));
		seq.push_back(mk_word(REQ_ALLOC, CNT_MAX, 0));
		seq.push_back(mk_word(REQ_ALLOC, NPAGES, 0));
		seq.push_back(mk_word(REQ_ALLOC, 1, 0));
		seq.push_back(mk_word(REQ_FREE, 0, (1 << OFF_W) - 1));
		seq.push_back(mk_word(REQ_FREE, CNT_MAX, 0));
		seq.push_back(mk_word(REQ_ALLOC, 1, 0));
		seq.push_back(mk_word(REQ_ALLOC, 3, 0));
		seq.push_back(mk_word(REQ_ALLOC, 2, 0));
		// drop the last page of a run, then free the rest of that run, which now lacks its last mark
		seq.push_back(mk_word(REQ_FREE, 0, 3 << PAGE_SHIFT));
		seq.push_back(mk_word(REQ_FREE, 0, 1 << PAGE_SHIFT));
		seq.push_back(mk_word(REQ_FREE, 0, 1 << PAGE_SHIFT));
		seq.push_back(mk_word(REQ_ALLOC, 4, 0));
		seq.push_back(mk_word(REQ_ALLOC, 3, 0));
		seq.push_back(mk_word(REQ_FREE, 0, 5 << PAGE_SHIFT));
		seq.push_back(mk_word(REQ_FREE, 0, 4 << PAGE_SHIFT));
		seq.push_back(mk_word(REQ_FREE, 0, (NPAGES - 1) << PAGE_SHIFT));
		seq.push_back(mk_word(REQ_FREE, 0, 1 << (PAGE_SHIFT - 1)));
		seq.push_back(mk_word(REQ_COUNT, 0, 0));
		seq.push_back(mk_word(REQ_ALLOC, 1000, 0));
		seq.push_back(mk_word(REQ_FREE, 0, 10 << PAGE_SHIFT));
		foreach (seq[i]) send_word(seq[i]);
	endtask

	initial begin
		int unsigned ph;
		int unsigned n;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		run_directed();
		for (ph = 0; ph < PHASES; ph++) begin
			write_pool(PHASE_POOL[ph]);
			for (n = 0; n < PHASE_ITEMS[ph]; n++) begin
				if ($urandom_range(0, 29) == 0) tx_calm = !tx_calm;
				if ($urandom_range(0, 29) == 0) rx_calm <= !rx_calm;
				send_word(random_word(sb.pool_pages()));
			end
		end
		wait_drained();
		repeat (16) @(posedge clk);
		if (sb.errors == 0)
			$display("PASS first_fit_page_allocator");
		else
			$display("FAIL first_fit_page_allocator");
		$finish;
	end
endmodule
